>>> sv/nmea_sentence_framer_checker_core_defines.svh
// Assertion macros used by the top level of the sentence framer.
`ifndef NMEA_SENTENCE_FRAMER_CHECKER_CORE_DEFINES_SVH
`define NMEA_SENTENCE_FRAMER_CHECKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define NSFC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define NSFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> sv/nsfc_pkg.sv
// Package with types, constants and helper functions of the sentence framer.
package nsfc_pkg;

    localparam int BYTE_W           = 8;
    localparam int MIN_IDX_W        = 7;
    localparam int END_IDX_W        = 7;
    localparam int DEFAULT_MAX_LINE = 128;

    localparam logic [MIN_IDX_W-1:0] MIN_END_INDEX_RESET = 7'd65;

    localparam logic [BYTE_W-1:0] CHAR_DOLLAR  = 8'h24;
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;

    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_MISMATCH  = 2'd1,
        ST_TOO_SHORT = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_GNGGA = 2'd1,
        KIND_GNRMC = 2'd2
    } t_kind;

    typedef struct packed {
        t_status               status;
        t_kind                 sentence_kind;
        logic [END_IDX_W-1:0]  end_index;
        logic [BYTE_W-1:0]     computed_checksum;
    } t_result;

    // Returns {valid, nibble}; valid is low for anything but 0-9, A-F, a-f.
    function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] c);
        logic [4:0] r;
        begin
            if (c >= 8'h30 && c <= 8'h39) begin
                r = {1'b1, 4'(c - 8'h30)};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                r = {1'b1, 4'(c - 8'h37)};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                r = {1'b1, 4'(c - 8'h57)};
            end else begin
                r = 5'd0;
            end
            return r;
        end
    endfunction

    // Characters of "GNGGA" after the dollar sign.
    function automatic logic [BYTE_W-1:0] gga_char(input logic [2:0] idx);
        logic [BYTE_W-1:0] c;
        begin
            unique case (idx)
                3'd0:    c = 8'h47;
                3'd1:    c = 8'h4E;
                3'd2:    c = 8'h47;
                3'd3:    c = 8'h47;
                3'd4:    c = 8'h41;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    // Characters of "GNRMC" after the dollar sign.
    function automatic logic [BYTE_W-1:0] rmc_char(input logic [2:0] idx);
        logic [BYTE_W-1:0] c;
        begin
            unique case (idx)
                3'd0:    c = 8'h47;
                3'd1:    c = 8'h4E;
                3'd2:    c = 8'h52;
                3'd3:    c = 8'h4D;
                3'd4:    c = 8'h43;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

endpackage

>>> sv/nsfc_ifs.sv
// Valid/ready channel interfaces for received bytes and sentence results.
interface nsfc_in_if;
    logic                         valid;
    logic                         ready;
    logic [nsfc_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsfc_out_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      status;
    logic [1:0]                      sentence_kind;
    logic [nsfc_pkg::END_IDX_W-1:0]  end_index;
    logic [nsfc_pkg::BYTE_W-1:0]     computed_checksum;

    modport source (output valid, output status, output sentence_kind,
                    output end_index, output computed_checksum, input ready);
    modport sink   (input valid, input status, input sentence_kind,
                    input end_index, input computed_checksum, output ready);
endinterface

>>> sv/nsfc_step.sv
// Per-byte next-state and result logic of the sentence framer.
module nsfc_step #(
    parameter int MAX_LINE = nsfc_pkg::DEFAULT_MAX_LINE,
    parameter int POS_W    = $clog2(MAX_LINE)
) (
    input  logic [nsfc_pkg::BYTE_W-1:0]    i_byte,
    input  logic [nsfc_pkg::MIN_IDX_W-1:0] i_min_end_index,
    input  logic                           i_in_sentence,
    input  logic [POS_W-1:0]               i_position,
    input  logic [nsfc_pkg::BYTE_W-1:0]    i_running_xor,
    input  logic [3:0][nsfc_pkg::BYTE_W-1:0] i_recent,
    input  logic                           i_gga_match,
    input  logic                           i_rmc_match,
    output logic                           o_in_sentence,
    output logic [POS_W-1:0]               o_position,
    output logic [nsfc_pkg::BYTE_W-1:0]    o_running_xor,
    output logic [3:0][nsfc_pkg::BYTE_W-1:0] o_recent,
    output logic                           o_gga_match,
    output logic                           o_rmc_match,
    output logic                           o_res_valid,
    output nsfc_pkg::t_result              o_res
);
    import nsfc_pkg::*;

    localparam int CMP_W = (POS_W > MIN_IDX_W) ? POS_W : MIN_IDX_W;

    logic [BYTE_W-1:0] sum;
    logic [4:0]        hi_dec;
    logic [4:0]        lo_dec;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  min_ext;
    logic [2:0]        prefix_idx;

    assign sum        = i_running_xor ^ i_recent[0] ^ i_recent[1] ^ i_recent[2] ^ i_recent[3];
    assign hi_dec     = hex_decode(i_recent[2]);
    assign lo_dec     = hex_decode(i_recent[1]);
    assign pos_ext    = CMP_W'(i_position);
    assign min_ext    = CMP_W'(i_min_end_index);
    assign prefix_idx = 3'(i_position - POS_W'(1));

    always_comb begin
        o_in_sentence = i_in_sentence;
        o_position    = i_position;
        o_running_xor = i_running_xor;
        o_recent      = i_recent;
        o_gga_match   = i_gga_match;
        o_rmc_match   = i_rmc_match;
        o_res_valid   = 1'b0;
        o_res         = '{status: ST_ACCEPTED, sentence_kind: KIND_OTHER,
                          end_index: '0, computed_checksum: '0};

        if (i_byte == CHAR_DOLLAR) begin
            // A dollar sign always opens a fresh sentence, even mid-sentence.
            o_in_sentence = 1'b1;
            o_position    = POS_W'(1);
            o_running_xor = '0;
            o_recent      = '0;
            o_gga_match   = 1'b1;
            o_rmc_match   = 1'b1;
        end else if (i_in_sentence) begin
            if (i_byte == CHAR_NEWLINE) begin
                o_res_valid             = 1'b1;
                o_res.end_index         = pos_ext[END_IDX_W-1:0];
                o_res.computed_checksum = sum;
                if (i_position > POS_W'(5)) begin
                    if (i_gga_match) begin
                        o_res.sentence_kind = KIND_GNGGA;
                    end else if (i_rmc_match) begin
                        o_res.sentence_kind = KIND_GNRMC;
                    end
                end
                if (pos_ext <= min_ext) begin
                    o_res.status = ST_TOO_SHORT;
                end else if (!hi_dec[4] || !lo_dec[4] || {hi_dec[3:0], lo_dec[3:0]} != sum) begin
                    o_res.status = ST_MISMATCH;
                end
                o_in_sentence = 1'b0;
                o_position    = '0;
            end else if (i_position >= POS_W'(MAX_LINE - 1)) begin
                // No room left for the newline: drop the sentence.
                o_res_valid   = 1'b1;
                o_res.status  = ST_OVERFLOW;
                o_in_sentence = 1'b0;
                o_position    = '0;
            end else begin
                if (i_position >= POS_W'(1) && i_position <= POS_W'(5)) begin
                    if (i_byte != gga_char(prefix_idx)) o_gga_match = 1'b0;
                    if (i_byte != rmc_char(prefix_idx)) o_rmc_match = 1'b0;
                end
                o_running_xor = i_running_xor ^ i_byte;
                o_recent      = {i_recent[2:0], i_byte};
                o_position    = i_position + POS_W'(1);
            end
        end
    end

endmodule

>>> sv/nsfc_result_buf.sv
// Two-entry result buffer: output register plus skid register.
module nsfc_result_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  nsfc_pkg::t_result i_data,
    output logic              o_has_room,
    output logic              o_valid,
    output nsfc_pkg::t_result o_data,
    input  logic              i_ready
);
    import nsfc_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    pop;

    assign pop        = r_out_valid && i_ready;
    assign o_has_room = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (pop) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (i_push) begin
            if (!n_out_valid) begin
                n_out       = i_data;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

>>> sv/nmea_sentence_framer_checker_core.sv
// Top level of the NMEA sentence framer and checksum checker.
//
// Received characters enter on the i_in request channel, one per accepted
// request, and may arrive in every clock cycle. A dollar sign opens a
// sentence; a newline closes it and produces one request on o_out with the
// status, the sentence kind, the newline index and the computed checksum.
// A sentence that would not fit in MAX_LINE characters is dropped with an
// overflow status. Characters outside a sentence produce nothing.
// A result enters the output register of the result buffer when its newline
// (or overflowing character) is accepted and that register is free, else it
// enters the skid register. One character is accepted per cycle while
// i_in.ready is high; the state update between the state registers and the result buffer is combinational.
// The result path is a two-entry buffer. When the receiver stalls, one more
// result fits in the skid register; i_in.ready drops only while both
// entries hold results, so characters keep flowing while one waits.
// Reset (synchronous, active low) leaves the block idle with empty buffers
// and sets the minimum end index to 65. i_cfg_we writes the minimum end
// index; it is meant to be written only while the block is idle.
`include "nmea_sentence_framer_checker_core_defines.svh"

module nmea_sentence_framer_checker_core #(
    parameter int MAX_LINE = nsfc_pkg::DEFAULT_MAX_LINE
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    nsfc_in_if.sink                        i_in,
    nsfc_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [nsfc_pkg::MIN_IDX_W-1:0] i_cfg_wdata
);
    import nsfc_pkg::*;

    localparam int POS_W = $clog2(MAX_LINE);

    // Sentence state carried from one character to the next.
    logic                    r_in_sentence;
    logic [POS_W-1:0]        r_position;
    logic [BYTE_W-1:0]       r_running_xor;
    logic [3:0][BYTE_W-1:0]  r_recent;
    logic                    r_gga_match;
    logic                    r_rmc_match;
    logic [MIN_IDX_W-1:0]    r_min_end_index;

    logic                    n_in_sentence;
    logic [POS_W-1:0]        n_position;
    logic [BYTE_W-1:0]       n_running_xor;
    logic [3:0][BYTE_W-1:0]  n_recent;
    logic                    n_gga_match;
    logic                    n_rmc_match;

    logic    res_valid;
    t_result res;
    logic    accept;
    logic    has_room;
    logic    out_valid;
    t_result out_data;

    assign i_in.ready = has_room;
    assign accept     = i_in.valid && has_room;

    nsfc_step #(
        .MAX_LINE (MAX_LINE),
        .POS_W    (POS_W)
    ) u_step (
        .i_byte          (i_in.rx_byte),
        .i_min_end_index (r_min_end_index),
        .i_in_sentence   (r_in_sentence),
        .i_position      (r_position),
        .i_running_xor   (r_running_xor),
        .i_recent        (r_recent),
        .i_gga_match     (r_gga_match),
        .i_rmc_match     (r_rmc_match),
        .o_in_sentence   (n_in_sentence),
        .o_position      (n_position),
        .o_running_xor   (n_running_xor),
        .o_recent        (n_recent),
        .o_gga_match     (n_gga_match),
        .o_rmc_match     (n_rmc_match),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    // Sentence state only advances on an accepted character request; i_cfg_we writes the minimum end index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sentence   <= 1'b0;
            r_position      <= '0;
            r_running_xor   <= '0;
            r_recent        <= '0;
            r_gga_match     <= 1'b1;
            r_rmc_match     <= 1'b1;
            r_min_end_index <= MIN_END_INDEX_RESET;
        end else begin
            if (accept) begin
                r_in_sentence <= n_in_sentence;
                r_position    <= n_position;
                r_running_xor <= n_running_xor;
                r_recent      <= n_recent;
                r_gga_match   <= n_gga_match;
                r_rmc_match   <= n_rmc_match;
            end
            if (i_cfg_we) begin
                r_min_end_index <= i_cfg_wdata;
            end
        end
    end

    nsfc_result_buf u_result_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept && res_valid),
        .i_data     (res),
        .o_has_room (has_room),
        .o_valid    (out_valid),
        .o_data     (out_data),
        .i_ready    (o_out.ready)
    );

    assign o_out.valid             = out_valid;
    assign o_out.status            = out_data.status;
    assign o_out.sentence_kind     = out_data.sentence_kind;
    assign o_out.end_index         = out_data.end_index;
    assign o_out.computed_checksum = out_data.computed_checksum;

    // Input back-pressure only happens while a result is waiting.
    `NSFC_ASSERT_IMPL(a_stall_has_result, i_clk, i_rst_n, !i_in.ready, o_out.valid)
    // An overflow drop reports all other fields as zero.
    `NSFC_ASSERT_IMPL(a_overflow_zero, i_clk, i_rst_n, o_out.valid && o_out.status == ST_OVERFLOW, o_out.sentence_kind == KIND_OTHER && o_out.end_index == '0 && o_out.computed_checksum == '0)
    // A dollar sign always restarts the sentence at index one.
    `NSFC_ASSERT_NEXT(a_dollar_opens, i_clk, i_rst_n, accept && i_in.rx_byte == CHAR_DOLLAR, r_in_sentence && r_position == POS_W'(1))
    // The position never runs past the last slot of the line buffer.
    `NSFC_ASSERT_IMPL(a_position_bound, i_clk, i_rst_n, 1'b1, r_position <= POS_W'(MAX_LINE - 1))

endmodule
